### sv/nearest_neighbor_stretch_assert.svh
// Assertion macros used by the scaler's datapath RTL file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef NEAREST_NEIGHBOR_STRETCH_ASSERT_SVH
`define NEAREST_NEIGHBOR_STRETCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NNS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/nns_pkg.sv
package nns_pkg;

  // Stored source frame geometry and fixed-point format.
  localparam int SRC_MAX_W = 256;
  localparam int SRC_MAX_H = 256;
  localparam int FRAC_BITS = 16;

  localparam int COL_BITS    = $clog2(SRC_MAX_W);
  localparam int ROW_BITS    = $clog2(SRC_MAX_H);
  localparam int FRAME_AW    = COL_BITS + ROW_BITS;
  localparam int FRAME_DEPTH = SRC_MAX_W * SRC_MAX_H;

  // Field and register widths.
  localparam int POS_BITS     = 12;
  localparam int PIX_BITS     = 32;
  localparam int SRC_DIM_BITS = 9;
  localparam int DST_DIM_BITS = 13;
  localparam int ORG_BITS     = 8;
  localparam int BPP_BITS     = 3;

  // Step, product and mapped coordinate widths.
  localparam int STEP_BITS      = SRC_DIM_BITS + FRAC_BITS;
  localparam int PROD_BITS      = POS_BITS + STEP_BITS;
  localparam int MAP_BITS       = PROD_BITS - FRAC_BITS;
  localparam int SRC_COORD_BITS = MAP_BITS + 1;
  localparam int DIV_CNT_BITS   = $clog2(STEP_BITS + 1);

  localparam logic [STEP_BITS-1:0] UNIT_STEP = STEP_BITS'(1) << FRAC_BITS;

  // Register file.
  localparam int NUM_REGS = 7;
  localparam int CFG_AW   = $clog2(NUM_REGS) + 2;
  localparam int CFG_DW   = 32;

  localparam logic [SRC_DIM_BITS-1:0] RST_SRC_DIM = SRC_DIM_BITS'(256);
  localparam logic [DST_DIM_BITS-1:0] RST_DST_DIM = DST_DIM_BITS'(256);
  localparam logic [BPP_BITS-1:0]     RST_BPP     = BPP_BITS'(4);

  typedef enum logic [CFG_AW-3:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_BPP
  } reg_idx_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [SRC_DIM_BITS-1:0] src_width;
    logic [SRC_DIM_BITS-1:0] src_height;
    logic [DST_DIM_BITS-1:0] dst_width;
    logic [DST_DIM_BITS-1:0] dst_height;
    logic [ORG_BITS-1:0]     origin_x;
    logic [ORG_BITS-1:0]     origin_y;
    logic [BPP_BITS-1:0]     bpp;
  } cfg_t;

  // Byte mask for a pixel size; zero acts as one byte, above four as four.
  function automatic logic [PIX_BITS-1:0] pixel_mask(input logic [BPP_BITS-1:0] bpp);
    logic [PIX_BITS-1:0] m;
    case (bpp) inside
      3'd0, 3'd1: m = 32'h0000_00FF;
      3'd2:       m = 32'h0000_FFFF;
      3'd3:       m = 32'h00FF_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### sv/nns_in_if.sv
interface nns_in_if;
  import nns_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  logic [PIX_BITS-1:0] pixel_in;

  modport source (output valid, cmd, pos_x, pos_y, pixel_in, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pixel_in, output ready);
endinterface

### sv/nns_out_if.sv
interface nns_out_if;
  import nns_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] pixel_out;
  logic                range_error;

  modport source (output valid, pixel_out, range_error, input ready);
  modport sink   (input valid, pixel_out, range_error, output ready);
endinterface

### sv/nns_step_div.sv
module nns_step_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [nns_pkg::STEP_BITS-1:0]     dividend,
  input  logic [nns_pkg::DST_DIM_BITS-1:0]  divisor,
  output logic [nns_pkg::STEP_BITS-1:0]     quotient,
  output logic                              busy
);
  import nns_pkg::*;

  logic [DIV_CNT_BITS-1:0] cnt;
  logic [STEP_BITS-1:0]    num;
  logic [STEP_BITS-1:0]    work;
  logic [DST_DIM_BITS-1:0] dvs;
  logic [DST_DIM_BITS-1:0] rem;
  logic [DST_DIM_BITS:0]   trial;
  logic                    qbit;
  logic [DST_DIM_BITS:0]   diff;

  // One restoring step: bring in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem, num[STEP_BITS-1]};
    qbit  = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  assign busy = (cnt != '0);

  // Iteration counter; the quotient register also holds the reset step.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      quotient <= UNIT_STEP;
    end else if (start) begin
      cnt <= DIV_CNT_BITS'(STEP_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_BITS'(1)) begin
        // A zero divisor yields a zero step.
        quotient <= (dvs == '0) ? '0 : {work[STEP_BITS-2:0], qbit};
      end
    end
  end

  // Working registers of the shift-subtract loop.
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      work <= '0;
    end else if (busy) begin
      num  <= {num[STEP_BITS-2:0], 1'b0};
      rem  <= qbit ? diff[DST_DIM_BITS-1:0] : trial[DST_DIM_BITS-1:0];
      work <= {work[STEP_BITS-2:0], qbit};
    end
  end
endmodule

### sv/nns_regs.sv
module nns_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nns_pkg::CFG_AW-1:0]   paddr,
  input  logic [nns_pkg::CFG_DW-1:0]   pwdata,
  output logic [nns_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output nns_pkg::cfg_t                cfg,
  output logic [nns_pkg::STEP_BITS-1:0] hstep,
  output logic [nns_pkg::STEP_BITS-1:0] vstep,
  output logic                         cfg_write,
  output logic                         cfg_busy
);
  import nns_pkg::*;

  reg_idx_t idx;
  logic     reg_known;
  logic     start;
  logic     hbusy;
  logic     vbusy;

  assign pready    = 1'b1;
  assign idx       = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_write = psel && penable && pwrite;
  assign cfg_busy  = start || hbusy || vbusy;

  // Decode whether the address names a register.
  always_comb begin
    case (idx)
      REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT,
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_BPP: reg_known = 1'b1;
      default: reg_known = 1'b0;
    endcase
  end

  // Register writes; a write to a known register restarts the step dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= RST_SRC_DIM;
      cfg.src_height <= RST_SRC_DIM;
      cfg.dst_width  <= RST_DST_DIM;
      cfg.dst_height <= RST_DST_DIM;
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.bpp        <= RST_BPP;
      start          <= 1'b0;
    end else begin
      start <= cfg_write && reg_known;
      if (cfg_write) begin
        case (idx)
          REG_SRC_WIDTH:  cfg.src_width  <= pwdata[SRC_DIM_BITS-1:0];
          REG_SRC_HEIGHT: cfg.src_height <= pwdata[SRC_DIM_BITS-1:0];
          REG_DST_WIDTH:  cfg.dst_width  <= pwdata[DST_DIM_BITS-1:0];
          REG_DST_HEIGHT: cfg.dst_height <= pwdata[DST_DIM_BITS-1:0];
          REG_ORIGIN_X:   cfg.origin_x   <= pwdata[ORG_BITS-1:0];
          REG_ORIGIN_Y:   cfg.origin_y   <= pwdata[ORG_BITS-1:0];
          REG_BPP:        cfg.bpp        <= pwdata[BPP_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_SRC_WIDTH:  prdata = CFG_DW'(cfg.src_width);
      REG_SRC_HEIGHT: prdata = CFG_DW'(cfg.src_height);
      REG_DST_WIDTH:  prdata = CFG_DW'(cfg.dst_width);
      REG_DST_HEIGHT: prdata = CFG_DW'(cfg.dst_height);
      REG_ORIGIN_X:   prdata = CFG_DW'(cfg.origin_x);
      REG_ORIGIN_Y:   prdata = CFG_DW'(cfg.origin_y);
      REG_BPP:        prdata = CFG_DW'(cfg.bpp);
      default:        prdata = '0;
    endcase
  end

  // Step = (src << FRAC_BITS) / dst on each axis.
  nns_step_div u_hdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend ({cfg.src_width, FRAC_BITS'(0)}),
    .divisor  (cfg.dst_width),
    .quotient (hstep),
    .busy     (hbusy)
  );

  nns_step_div u_vdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend ({cfg.src_height, FRAC_BITS'(0)}),
    .divisor  (cfg.dst_height),
    .quotient (vstep),
    .busy     (vbusy)
  );
endmodule

### sv/nns_datapath.sv
`include "nearest_neighbor_stretch_assert.svh"

module nns_datapath (
  input  logic                          clk,
  input  logic                          rst,
  nns_in_if.sink                        req,
  nns_out_if.source                     rsp,
  input  nns_pkg::cfg_t                 cfg,
  input  logic [nns_pkg::STEP_BITS-1:0] hstep,
  input  logic [nns_pkg::STEP_BITS-1:0] vstep,
  input  logic                          hold
);
  import nns_pkg::*;

  // Stage A: products and range checks of the accepted word.
  logic                 a_valid;
  logic                 a_cmd;
  logic                 a_in_frame;
  logic                 a_dst_err;
  logic [FRAME_AW-1:0]  a_load_addr;
  logic [PIX_BITS-1:0]  a_pix;
  logic [PROD_BITS-1:0] a_prod_x;
  logic [PROD_BITS-1:0] a_prod_y;

  // Stage B: frame read data.
  logic                 b_valid;
  logic                 b_fetch;
  logic                 b_err;
  logic [PIX_BITS-1:0]  b_pix;

  // Output register.
  logic                 out_valid;
  logic [PIX_BITS-1:0]  out_pixel;
  logic                 out_err;

  logic                      accept;
  logic                      out_free;
  logic                      a_adv;
  logic [SRC_COORD_BITS-1:0] sx;
  logic [SRC_COORD_BITS-1:0] sy;
  logic                      fetch_err;
  logic [FRAME_AW-1:0]       mem_addr;
  logic                      mem_we;
  logic                      mem_re;

  logic [PIX_BITS-1:0] frame [FRAME_DEPTH];

  // Handshake and stage advance.
  assign out_free  = !out_valid || rsp.ready;
  assign a_adv     = a_valid && (!b_valid || out_free);
  assign req.ready = !hold && (!a_valid || a_adv);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = out_valid;
  assign rsp.pixel_out   = out_pixel;
  assign rsp.range_error = out_err;

  // Mapped source coordinate and frame address.
  always_comb begin
    sx = SRC_COORD_BITS'(cfg.origin_x) + SRC_COORD_BITS'(a_prod_x[PROD_BITS-1:FRAC_BITS]);
    sy = SRC_COORD_BITS'(cfg.origin_y) + SRC_COORD_BITS'(a_prod_y[PROD_BITS-1:FRAC_BITS]);
    fetch_err = a_dst_err || (sx >= SRC_COORD_BITS'(SRC_MAX_W)) ||
                (sy >= SRC_COORD_BITS'(SRC_MAX_H));
    mem_addr = (a_cmd == CMD_LOAD) ? a_load_addr : {sy[ROW_BITS-1:0], sx[COL_BITS-1:0]};
    mem_we   = a_adv && (a_cmd == CMD_LOAD) && a_in_frame;
    mem_re   = a_adv && (a_cmd == CMD_FETCH) && !fetch_err;
  end

  // Source frame: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame[mem_addr] <= a_pix;
    end
    if (mem_re) begin
      b_pix <= frame[mem_addr];
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (out_free) begin
        b_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= b_valid && b_fetch;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd       <= req.cmd;
      a_in_frame  <= (32'(req.pos_x) < SRC_MAX_W) && (32'(req.pos_y) < SRC_MAX_H);
      a_dst_err   <= ({1'b0, req.pos_x} >= cfg.dst_width) ||
                     ({1'b0, req.pos_y} >= cfg.dst_height);
      a_load_addr <= {req.pos_y[ROW_BITS-1:0], req.pos_x[COL_BITS-1:0]};
      a_pix       <= req.pixel_in & pixel_mask(cfg.bpp);
      a_prod_x    <= PROD_BITS'(req.pos_x) * PROD_BITS'(hstep);
      a_prod_y    <= PROD_BITS'(req.pos_y) * PROD_BITS'(vstep);
    end
    if (a_adv) begin
      b_fetch <= (a_cmd == CMD_FETCH);
      b_err   <= fetch_err;
    end
    if (out_free && b_valid && b_fetch) begin
      out_pixel <= b_err ? '0 : (b_pix & pixel_mask(cfg.bpp));
      out_err   <= b_err;
    end
  end

  // Checks.
  `NNS_ASSERT_SAME(a_mem_one_access, mem_we, !mem_re)
  `NNS_ASSERT_NEXT(a_fetch_to_out, b_valid && b_fetch && out_free, out_valid)
  `NNS_ASSERT_SAME(a_err_zero_pixel, out_valid && out_err, out_pixel == '0)
  `NNS_ASSERT_NEXT(a_b_held_on_stall, b_valid && !out_free, b_valid)
endmodule

### sv/nearest_neighbor_stretch.sv
// Nearest-neighbor stretch over a stored 256 x 256 source frame.
// Input channel req carries words of cmd, pos_x, pos_y and pixel_in. A load
// word (cmd 0) writes pixel_in, masked to bytes_per_pixel, into the frame at
// (pos_x, pos_y) and gives no result. A fetch word (cmd 1) gives one result on
// rsp: the source pixel that the destination pixel maps to, or range_error
// with a zero pixel when either coordinate falls outside its range.
// Throughput is one word per clock while rsp is not stalled and no register
// write is in progress; the frame memory takes one access a cycle. A fetch
// result passes the multiply stage, frame read stage and output register.
// The APB port holds the seven geometry registers. Each write to a known
// register restarts two bit-serial dividers for the 9.16 steps; req.ready
// stays low during the write and while they run.
// Synchronous reset clears the pipeline and loads the reset geometry with a
// unit step on both axes; the frame contents are not cleared.
// When rsp is stalled the result waits in the output register, and the
// frame read and multiply stages behind it still fill before req.ready drops.
module nearest_neighbor_stretch (
  input  logic                       clk,
  input  logic                       rst,
  nns_in_if.sink                     req,
  nns_out_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nns_pkg::CFG_AW-1:0] paddr,
  input  logic [nns_pkg::CFG_DW-1:0] pwdata,
  output logic [nns_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import nns_pkg::*;

  cfg_t                 cfg;
  logic [STEP_BITS-1:0] hstep;
  logic [STEP_BITS-1:0] vstep;
  logic                 cfg_write;
  logic                 cfg_busy;

  // Register file and step dividers.
  nns_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .hstep     (hstep),
    .vstep     (vstep),
    .cfg_write (cfg_write),
    .cfg_busy  (cfg_busy)
  );

  // Mapping pipeline around the frame memory.
  nns_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg),
    .hstep (hstep),
    .vstep (vstep),
    .hold  (cfg_busy || cfg_write)
  );
endmodule

### tb/nns_stretch_checker.sv
`timescale 1ns / 100ps

// Watches the word channels and the register port of the stretch block.
// It keeps its own copy of the frame and the geometry, predicts every fetch
// result and compares each result word with the oldest prediction.
module nns_stretch_checker (
  input  logic                       clk,
  input  logic                       rst,
  nns_in_if                          req,
  nns_out_if                         rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nns_pkg::CFG_AW-1:0] paddr,
  input  logic [nns_pkg::CFG_DW-1:0] pwdata,
  input  logic                       pready,
  output int                         fails,
  output int                         pending,
  output int                         checked,
  output int                         range_hits
);
  import nns_pkg::*;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                range_error;
  } fetch_result_t;

  cfg_t                geom;
  logic [PIX_BITS-1:0] frame_copy [FRAME_DEPTH];
  fetch_result_t       expected_pixels [$];
  int                  fail_count    = 0;
  int                  checked_count = 0;
  int                  range_count   = 0;

  // Low bytes kept for a pixel size; zero counts as one byte, above four as four.
  function automatic logic [PIX_BITS-1:0] lane_mask(input logic [BPP_BITS-1:0] size);
    int lanes;
    lanes = (size == 0) ? 1 : (size > 4) ? 4 : int'(size);
    if (lanes == 4) return '1;
    return (PIX_BITS'(1) << (8 * lanes)) - PIX_BITS'(1);
  endfunction

  // DDA increment in 9.16 fixed point; a zero destination gives a zero step.
  function automatic logic [STEP_BITS-1:0] dda_step(input logic [SRC_DIM_BITS-1:0] src,
                                                    input logic [DST_DIM_BITS-1:0] dst);
    logic [STEP_BITS-1:0] scaled;
    scaled = STEP_BITS'(src) << FRAC_BITS;
    if (dst == '0) return '0;
    return scaled / STEP_BITS'(dst);
  endfunction

  // Nearest source pixel for a destination pixel under the current geometry.
  function automatic fetch_result_t nearest_pixel(input logic [POS_BITS-1:0] x,
                                                  input logic [POS_BITS-1:0] y);
    logic [PROD_BITS-1:0]      col_prod;
    logic [PROD_BITS-1:0]      row_prod;
    logic [SRC_COORD_BITS-1:0] col;
    logic [SRC_COORD_BITS-1:0] row;
    fetch_result_t             res;
    res.pixel       = '0;
    res.range_error = 1'b1;
    if (x >= geom.dst_width || y >= geom.dst_height) return res;
    col_prod = PROD_BITS'(x) * PROD_BITS'(dda_step(geom.src_width, geom.dst_width));
    row_prod = PROD_BITS'(y) * PROD_BITS'(dda_step(geom.src_height, geom.dst_height));
    col = SRC_COORD_BITS'(geom.origin_x) + SRC_COORD_BITS'(col_prod >> FRAC_BITS);
    row = SRC_COORD_BITS'(geom.origin_y) + SRC_COORD_BITS'(row_prod >> FRAC_BITS);
    if (col >= SRC_MAX_W || row >= SRC_MAX_H) return res;
    res.pixel       = frame_copy[int'(row) * SRC_MAX_W + int'(col)] & lane_mask(geom.bpp);
    res.range_error = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    fetch_result_t want;
    if (rst) begin
      geom.src_width  = RST_SRC_DIM;
      geom.src_height = RST_SRC_DIM;
      geom.dst_width  = RST_DST_DIM;
      geom.dst_height = RST_DST_DIM;
      geom.origin_x   = '0;
      geom.origin_y   = '0;
      geom.bpp        = RST_BPP;
      expected_pixels.delete();
    end else begin
      // Result side first: no result can belong to a fetch taken at this edge.
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with no fetch outstanding: pixel_out %h range_error %b",
                 rsp.pixel_out, rsp.range_error);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          checked_count++;
          if (want.range_error) range_count++;
          if (rsp.pixel_out !== want.pixel) begin
            $error("pixel_out: expected %h, actual %h", want.pixel, rsp.pixel_out);
            fail_count++;
          end
          if (rsp.range_error !== want.range_error) begin
            $error("range_error: expected %b, actual %b", want.range_error, rsp.range_error);
            fail_count++;
          end
        end
      end

      // A register write applies to every word accepted after it.
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_SRC_WIDTH:  geom.src_width  = pwdata[SRC_DIM_BITS-1:0];
          REG_SRC_HEIGHT: geom.src_height = pwdata[SRC_DIM_BITS-1:0];
          REG_DST_WIDTH:  geom.dst_width  = pwdata[DST_DIM_BITS-1:0];
          REG_DST_HEIGHT: geom.dst_height = pwdata[DST_DIM_BITS-1:0];
          REG_ORIGIN_X:   geom.origin_x   = pwdata[ORG_BITS-1:0];
          REG_ORIGIN_Y:   geom.origin_y   = pwdata[ORG_BITS-1:0];
          REG_BPP:        geom.bpp        = pwdata[BPP_BITS-1:0];
          default: ;
        endcase
      end

      // Loads update the frame copy with the mask in force; fetches queue a prediction.
      if (req.valid && req.ready) begin
        if (req.cmd == CMD_LOAD) begin
          if (req.pos_x < SRC_MAX_W && req.pos_y < SRC_MAX_H)
            frame_copy[int'(req.pos_y) * SRC_MAX_W + int'(req.pos_x)] =
              req.pixel_in & lane_mask(geom.bpp);
        end else begin
          expected_pixels.push_back(nearest_pixel(req.pos_x, req.pos_y));
        end
      end
    end
    fails      <= fail_count;
    pending    <= expected_pixels.size();
    checked    <= checked_count;
    range_hits <= range_count;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import nns_pkg::*;

  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES    = 8;
  localparam logic [CFG_AW-3:0] REG_UNUSED = (CFG_AW-2)'(NUM_REGS);

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fails;
  int pending;
  int checked;
  int range_hits;

  // Geometry as last written, and which frame entries hold a loaded pixel.
  cfg_t geom;
  bit   loaded [FRAME_DEPTH];

  int items_sent   = 0;
  int loads_sent   = 0;
  int fetches_sent = 0;
  int send_quiet   = 0;
  int sink_quiet   = 0;

  nns_in_if  req_ch ();
  nns_out_if rsp_ch ();

  nearest_neighbor_stretch dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nns_stretch_checker stretch_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fails      (fails),
    .pending    (pending),
    .checked    (checked),
    .range_hits (range_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Wait before the next word, with occasional runs of back-to-back words.
  function automatic int draw_wait(inout int quiet_run);
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_run = $urandom_range(8, 40);
    return $urandom_range(0, 11);
  endfunction

  // Frame entry that a fetch would read, or -1 when it reads none.
  function automatic int source_entry(input int x, input int y);
    longint col;
    longint row;
    if (x >= geom.dst_width || y >= geom.dst_height) return -1;
    col = longint'(geom.origin_x) + ((longint'(x) *
          ((longint'(geom.src_width) << FRAC_BITS) / longint'(geom.dst_width))) >> FRAC_BITS);
    row = longint'(geom.origin_y) + ((longint'(y) *
          ((longint'(geom.src_height) << FRAC_BITS) / longint'(geom.dst_height))) >> FRAC_BITS);
    if (col >= SRC_MAX_W || row >= SRC_MAX_H) return -1;
    return int'(row) * SRC_MAX_W + int'(col);
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_word(input cmd_t op, input int x, input int y,
                           input logic [PIX_BITS-1:0] pix);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= op;
    req_ch.pos_x    <= POS_BITS'(x);
    req_ch.pos_y    <= POS_BITS'(y);
    req_ch.pixel_in <= pix;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_load(input int x, input int y, input logic [PIX_BITS-1:0] pix);
    send_word(CMD_LOAD, x, y, pix);
    items_sent++;
    loads_sent++;
    if (x < SRC_MAX_W && y < SRC_MAX_H) begin
      loaded[y * SRC_MAX_W + x] = 1'b1;
    end
  endtask

  // A fetch whose source pixel was never loaded gets a load in front of it.
  task automatic fetch_at(input int x, input int y);
    int entry;
    entry = source_entry(x, y);
    if (entry >= 0 && !loaded[entry])
      send_load(entry % SRC_MAX_W, entry / SRC_MAX_W, $urandom());
    send_word(CMD_FETCH, x, y, $urandom());
    items_sent++;
    fetches_sent++;
  endtask

  // Let every outstanding result and any load still in the pipe finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, access phase, then back to idle.
  task automatic write_reg(input logic [CFG_AW-3:0] idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  geom.src_width  = value[SRC_DIM_BITS-1:0];
      REG_SRC_HEIGHT: geom.src_height = value[SRC_DIM_BITS-1:0];
      REG_DST_WIDTH:  geom.dst_width  = value[DST_DIM_BITS-1:0];
      REG_DST_HEIGHT: geom.dst_height = value[DST_DIM_BITS-1:0];
      REG_ORIGIN_X:   geom.origin_x   = value[ORG_BITS-1:0];
      REG_ORIGIN_Y:   geom.origin_y   = value[ORG_BITS-1:0];
      REG_BPP:        geom.bpp        = value[BPP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Result side: before each word, ready drops for a random wait that can be zero.
  initial begin : result_sink
    int hold;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = draw_wait(sink_quiet);
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_t g;
    int   start;
    int   pick;
    int   span;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_LOAD;
    req_ch.pos_x    <= '0;
    req_ch.pos_y    <= '0;
    req_ch.pixel_in <= '0;
    geom.src_width  = RST_SRC_DIM;
    geom.src_height = RST_SRC_DIM;
    geom.dst_width  = RST_DST_DIM;
    geom.dst_height = RST_DST_DIM;
    geom.origin_x   = '0;
    geom.origin_y   = '0;
    geom.bpp        = RST_BPP;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Frame corners, loads outside the frame, and fetches on both sides of the edges.
    send_load(0, 0, 32'hFFFF_FFFF);
    send_load(255, 255, 32'hA5A5_5A5A);
    send_load(255, 0, 32'h0000_0001);
    send_load(0, 255, 32'h8000_0000);
    send_load(4095, 4095, 32'h1234_5678);
    send_load(256, 0, 32'h0F0F_0F0F);
    send_load(0, 256, 32'hF0F0_F0F0);
    fetch_at(0, 0);
    fetch_at(255, 255);
    fetch_at(255, 0);
    fetch_at(0, 255);
    fetch_at(256, 0);
    fetch_at(0, 256);
    fetch_at(4095, 4095);
    // A fetch right behind the load of the same pixel.
    send_load(7, 7, 32'hDEAD_BEEF);
    fetch_at(7, 7);

    // A pixel stored under a narrow size keeps that mask under a wider one.
    settle();
    write_reg(REG_BPP, 2);
    send_load(1, 1, 32'h1234_5678);
    settle();
    write_reg(REG_BPP, 4);
    fetch_at(1, 1);
    // Size zero reads back one byte.
    settle();
    write_reg(REG_BPP, 0);
    fetch_at(0, 0);
    // Origin pushes the mapped column past the frame edge, and onto its last column.
    settle();
    write_reg(REG_ORIGIN_X, 200);
    fetch_at(100, 0);
    fetch_at(55, 0);

    // Geometry phases: extremes first, then random settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: g = '{src_width: 1, src_height: 1, dst_width: 1, dst_height: 1,
                 origin_x: 0, origin_y: 0, bpp: 1};
        1: g = '{src_width: 511, src_height: 511, dst_width: 1, dst_height: 1,
                 origin_x: 255, origin_y: 255, bpp: 7};
        2: g = '{src_width: 511, src_height: 256, dst_width: 4096, dst_height: 4096,
                 origin_x: 0, origin_y: 0, bpp: 0};
        3: g = '{src_width: 0, src_height: 0, dst_width: 0, dst_height: 0,
                 origin_x: 17, origin_y: 3, bpp: 2};
        4: g = '{src_width: 0, src_height: 0, dst_width: 300, dst_height: 4096,
                 origin_x: 255, origin_y: 0, bpp: 3};
        default: begin
          g.src_width  = ($urandom_range(0, 4) == 0) ? SRC_DIM_BITS'($urandom_range(1, 511))
                                                     : SRC_DIM_BITS'($urandom_range(1, 16));
          g.src_height = ($urandom_range(0, 4) == 0) ? SRC_DIM_BITS'($urandom_range(1, 511))
                                                     : SRC_DIM_BITS'($urandom_range(1, 16));
          g.dst_width  = ($urandom_range(0, 4) == 0) ? DST_DIM_BITS'($urandom_range(1, 4096))
                                                     : DST_DIM_BITS'($urandom_range(1, 64));
          g.dst_height = ($urandom_range(0, 4) == 0) ? DST_DIM_BITS'($urandom_range(1, 4096))
                                                     : DST_DIM_BITS'($urandom_range(1, 64));
          g.origin_x   = ORG_BITS'($urandom_range(0, 255));
          g.origin_y   = ORG_BITS'($urandom_range(0, 255));
          g.bpp        = BPP_BITS'($urandom_range(0, 7));
        end
      endcase
      settle();
      write_reg(REG_SRC_WIDTH, CFG_DW'(g.src_width));
      write_reg(REG_SRC_HEIGHT, CFG_DW'(g.src_height));
      write_reg(REG_DST_WIDTH, CFG_DW'(g.dst_width));
      write_reg(REG_DST_HEIGHT, CFG_DW'(g.dst_height));
      write_reg(REG_ORIGIN_X, CFG_DW'(g.origin_x));
      write_reg(REG_ORIGIN_Y, CFG_DW'(g.origin_y));
      write_reg(REG_BPP, CFG_DW'(g.bpp));
      write_reg(REG_UNUSED, $urandom());

      // Mostly fetches inside the destination, plus loads into the source rectangle and fetches and loads anywhere.
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 55 && geom.dst_width != 0 && geom.dst_height != 0) begin
          fetch_at($urandom_range(0, geom.dst_width - 1), $urandom_range(0, geom.dst_height - 1));
        end else if (pick < 70) begin
          fetch_at($urandom_range(0, 4095), $urandom_range(0, 4095));
        end else if (pick < 90) begin
          span = (geom.src_width == 0) ? 1 : int'(geom.src_width);
          send_load(geom.origin_x + $urandom_range(0, span - 1),
                    geom.origin_y + $urandom_range(0, ((geom.src_height == 0) ? 1
                                                       : int'(geom.src_height)) - 1),
                    $urandom());
        end else begin
          send_load($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
        end
      end
    end

    settle();
    $display("Covered %0d words (%0d loads, %0d fetches) over %0d geometry phases.",
             items_sent, loads_sent, fetches_sent, PHASES);
    $display("Checked %0d result words, %0d of them flagged out of range.",
             checked, range_hits);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
